// File: rtl/lmf_pkg.sv
package lmf_pkg;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 16;
  localparam int TIME_W = 48;

  // forwarding decision codes
  typedef enum logic [1:0] {
    ACT_ABORT    = 2'd0,
    ACT_FLOOD    = 2'd1,
    ACT_REDIRECT = 2'd2
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LEARN,
    ST_RESULT
  } state_t;

  // table access strobes from sequencer to table
  typedef struct packed {
    logic mac_rd;
    logic port_rd;
    logic insert;
    logic refresh;
  } tbl_cmd_t;

  // hit flags from compare unit
  typedef struct packed {
    logic src_hit;
    logic dst_hit;
  } match_t;

endpackage

// File: rtl/lmf_if.sv
interface lmf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       header_complete;
  logic [lmf_pkg::MAC_W-1:0]  dst_mac;
  logic [lmf_pkg::MAC_W-1:0]  src_mac;
  logic [lmf_pkg::PORT_W-1:0] ingress_port;
  logic [lmf_pkg::TIME_W-1:0] arrival_time;

  modport source (output valid, header_complete, dst_mac, src_mac, ingress_port,
                  arrival_time, input ready);
  modport sink (input valid, header_complete, dst_mac, src_mac, ingress_port,
                arrival_time, output ready);
endinterface

interface lmf_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [lmf_pkg::PORT_W-1:0] egress_port;
  logic                       new_entry_valid;
  logic [lmf_pkg::MAC_W-1:0]  new_entry_mac;
  logic [lmf_pkg::PORT_W-1:0] new_entry_port;
  logic [lmf_pkg::TIME_W-1:0] new_entry_time;
  logic                       table_full;

  modport source (output valid, action, egress_port, new_entry_valid, new_entry_mac,
                  new_entry_port, new_entry_time, table_full, input ready);
  modport sink (input valid, action, egress_port, new_entry_valid, new_entry_mac,
                new_entry_port, new_entry_time, table_full, output ready);
endinterface

// File: rtl/lmf_match.sv
module lmf_match #(
  parameter int IDX_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      valid,
  input  logic [IDX_W-1:0]          idx,
  input  logic [lmf_pkg::MAC_W-1:0] entry_mac,
  input  logic [lmf_pkg::MAC_W-1:0] src_key,
  input  logic [lmf_pkg::MAC_W-1:0] dst_key,
  output lmf_pkg::match_t           hits,
  output logic [IDX_W-1:0]          src_idx,
  output logic [IDX_W-1:0]          dst_idx
);

  logic src_eq;
  logic dst_eq;

  // one entry compared against both keys per cycle
  assign src_eq = valid && (entry_mac == src_key);
  assign dst_eq = valid && (entry_mac == dst_key);

  // hit flags, first match wins
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hits <= '0;
    end else begin
      if (src_eq && !hits.src_hit) begin
        hits.src_hit <= 1'b1;
      end
      if (dst_eq && !hits.dst_hit) begin
        hits.dst_hit <= 1'b1;
      end
    end
  end

  // matching slot indexes
  always_ff @(posedge clk) begin
    if (src_eq && !hits.src_hit) begin
      src_idx <= idx;
    end
    if (dst_eq && !hits.dst_hit) begin
      dst_idx <= idx;
    end
  end

endmodule

// File: rtl/lmf_table.sv
module lmf_table #(
  parameter int ENTRIES = 256,
  parameter int IDX_W   = 8
) (
  input  logic                       clk,
  input  lmf_pkg::tbl_cmd_t          cmd,
  input  logic [IDX_W-1:0]           mac_rd_idx,
  input  logic [IDX_W-1:0]           port_rd_idx,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic [lmf_pkg::MAC_W-1:0]  wr_mac,
  input  logic [lmf_pkg::PORT_W-1:0] wr_port,
  input  logic [lmf_pkg::TIME_W-1:0] wr_time,
  output logic [lmf_pkg::MAC_W-1:0]  rd_mac,
  output logic [lmf_pkg::PORT_W-1:0] rd_port
);

  logic [lmf_pkg::MAC_W-1:0]  mac_mem  [ENTRIES];
  logic [lmf_pkg::PORT_W-1:0] port_mem [ENTRIES];
  logic [lmf_pkg::TIME_W-1:0] time_mem [ENTRIES];

  // mac store: insert write, scan read
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mac_mem[wr_idx] <= wr_mac;
    end
    if (cmd.mac_rd) begin
      rd_mac <= mac_mem[mac_rd_idx];
    end
  end

  // port store: insert write, destination read
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      port_mem[wr_idx] <= wr_port;
    end
    if (cmd.port_rd) begin
      rd_port <= port_mem[port_rd_idx];
    end
  end

  // timestamp store: written on insert and refresh
  always_ff @(posedge clk) begin
    if (cmd.insert || cmd.refresh) begin
      time_mem[wr_idx] <= wr_time;
    end
  end

endmodule

// File: rtl/l2_mac_learning_forwarder.sv
// channel | dir | fields
// din     | in  | header_complete, dst_mac, src_mac, ingress_port, arrival_time
// dout    | out | action, egress_port, new_entry_valid, new_entry_mac,
//         |     | new_entry_port, new_entry_time, table_full
//
// an item scans every learned entry, then passes drain, learn and result; with an
// empty table it skips scan and drain, and a truncated header goes straight to result. the mac
// store read port sets the scan, one entry per cycle through the shared compare unit.
// reset clears the sequencer, the output valid and the fill count; stores need no
// clearing since slots fill from index 0 upward. din is not ready while an item is
// in work; a finished result waits in the output register until dout takes it.
module l2_mac_learning_forwarder #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  lmf_in_if.sink    din,
  lmf_out_if.source dout
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  lmf_pkg::state_t   state;
  lmf_pkg::state_t   state_next;
  lmf_pkg::tbl_cmd_t cmd;
  lmf_pkg::match_t   hits;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] src_idx;
  logic [IDX_W-1:0] dst_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             accept;
  logic             scan_last;
  logic             is_full;
  logic             clear;

  // latched item
  logic                       complete;
  logic [lmf_pkg::MAC_W-1:0]  dst_mac;
  logic [lmf_pkg::MAC_W-1:0]  src_mac;
  logic [lmf_pkg::PORT_W-1:0] in_port;
  logic [lmf_pkg::TIME_W-1:0] in_time;

  // learn outcome
  logic new_v;
  logic full_v;
  logic self_hit;
  logic dst_found;

  logic [lmf_pkg::MAC_W-1:0]  rd_mac;
  logic [lmf_pkg::PORT_W-1:0] rd_port;

  logic load_out;

  assign accept    = din.valid && din.ready;
  assign scan_last = (CNT_W'(scan_idx) == count - CNT_W'(1));
  assign is_full   = (count == CNT_W'(TABLE_ENTRIES));
  assign clear     = accept;
  assign load_out  = (state == lmf_pkg::ST_RESULT) && (!dout.valid || dout.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lmf_pkg::ST_IDLE: begin
        if (accept) begin
          if (!din.header_complete) begin
            state_next = lmf_pkg::ST_RESULT;
          end else if (count == '0) begin
            state_next = lmf_pkg::ST_LEARN;
          end else begin
            state_next = lmf_pkg::ST_SCAN;
          end
        end
      end
      lmf_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = lmf_pkg::ST_DRAIN;
        end
      end
      lmf_pkg::ST_DRAIN:  state_next = lmf_pkg::ST_LEARN;
      lmf_pkg::ST_LEARN:  state_next = lmf_pkg::ST_RESULT;
      lmf_pkg::ST_RESULT: begin
        if (load_out) begin
          state_next = lmf_pkg::ST_IDLE;
        end
      end
      default: state_next = lmf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd       = '0;
    din.ready = 1'b0;
    wr_idx    = src_idx;
    case (state)
      lmf_pkg::ST_IDLE: din.ready = 1'b1;
      lmf_pkg::ST_SCAN: cmd.mac_rd = 1'b1;
      lmf_pkg::ST_LEARN: begin
        cmd.port_rd = hits.dst_hit;
        if (hits.src_hit) begin
          cmd.refresh = 1'b1;
        end else if (!is_full) begin
          cmd.insert = 1'b1;
          wr_idx     = IDX_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lmf_pkg::ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= cmd.mac_rd;
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // scan address and compare tag
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (accept) begin
      scan_idx <= '0;
    end else if (cmd.mac_rd) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      complete <= din.header_complete;
      dst_mac  <= din.dst_mac;
      src_mac  <= din.src_mac;
      in_port  <= din.ingress_port;
      in_time  <= din.arrival_time;
    end
  end

  // learn outcome
  always_ff @(posedge clk) begin
    if (accept) begin
      new_v     <= 1'b0;
      full_v    <= 1'b0;
      self_hit  <= 1'b0;
      dst_found <= 1'b0;
    end else if (state == lmf_pkg::ST_LEARN) begin
      new_v     <= !hits.src_hit;
      full_v    <= !hits.src_hit && is_full;
      self_hit  <= !hits.src_hit && !is_full && (dst_mac == src_mac);
      dst_found <= hits.dst_hit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (load_out) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!complete) begin
        dout.action          <= lmf_pkg::ACT_ABORT;
        dout.egress_port     <= '0;
        dout.new_entry_valid <= 1'b0;
        dout.new_entry_mac   <= '0;
        dout.new_entry_port  <= '0;
        dout.new_entry_time  <= '0;
        dout.table_full      <= 1'b0;
      end else begin
        if (dst_found) begin
          dout.action      <= lmf_pkg::ACT_REDIRECT;
          dout.egress_port <= rd_port;
        end else if (self_hit) begin
          dout.action      <= lmf_pkg::ACT_REDIRECT;
          dout.egress_port <= in_port;
        end else begin
          dout.action      <= lmf_pkg::ACT_FLOOD;
          dout.egress_port <= '0;
        end
        dout.new_entry_valid <= new_v;
        dout.new_entry_mac   <= new_v ? src_mac : '0;
        dout.new_entry_port  <= new_v ? in_port : '0;
        dout.new_entry_time  <= new_v ? in_time : '0;
        dout.table_full      <= full_v;
      end
    end
  end

  lmf_match #(
    .IDX_W(IDX_W)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .valid     (cmp_valid),
    .idx       (cmp_idx),
    .entry_mac (rd_mac),
    .src_key   (src_mac),
    .dst_key   (dst_mac),
    .hits      (hits),
    .src_idx   (src_idx),
    .dst_idx   (dst_idx)
  );

  lmf_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk         (clk),
    .cmd         (cmd),
    .mac_rd_idx  (scan_idx),
    .port_rd_idx (dst_idx),
    .wr_idx      (wr_idx),
    .wr_mac      (src_mac),
    .wr_port     (in_port),
    .wr_time     (in_time),
    .rd_mac      (rd_mac),
    .rd_port     (rd_port)
  );

endmodule
